@@ rtl/bts_pkg.sv @@
// ============================================================================
// bts_pkg: shared types and constants of the bilinear texture sampler
// Holds the configuration, queue beat and front item types, the edge mode
// and opcode codes, and the size clamp used by both axes.
// ============================================================================
package bts_pkg;

    // Default texture limits.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Fixed widths of the store and the payload.
    localparam int ADDR_W      = 16;
    localparam int TEXEL_W     = 32;
    localparam int STORE_DEPTH = 65536;
    localparam int CHAN_W      = 8;
    localparam int SRC_W       = 31;
    localparam int HALF_W      = 32;
    localparam int COORD_W     = 24;
    localparam int AXIS_LAT    = COORD_W + 1;
    localparam int SIZE_W      = 9;
    localparam int CALC_W      = 14;
    localparam int FRAC_W      = 8;
    localparam int WEIGHT_W    = 17;
    localparam int SUM_W       = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [HALF_W-1:0]   HALF_TEXEL  = 32'd128;
    localparam logic [SIZE_W-1:0]   OPACITY_ONE = 9'd256;
    localparam logic [SIZE_W-1:0]   FRAC_ONE    = 9'd256;
    localparam logic [SUM_W-1:0]    ROUND_HALF  = 24'd32768;

    typedef enum logic [1:0] {
        EDGE_NONE    = 2'd0,
        EDGE_PAD     = 2'd1,
        EDGE_REFLECT = 2'd2,
        EDGE_REPEAT  = 2'd3
    } edge_mode_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMG_WIDTH  = 3'd0,
        CFG_IMG_HEIGHT = 3'd1,
        CFG_H_MODE     = 3'd2,
        CFG_V_MODE     = 3'd3,
        CFG_OPACITY    = 3'd4,
        CFG_NEAREST    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [SIZE_W-1:0] img_width;
        logic [SIZE_W-1:0] img_height;
        edge_mode_t        h_mode;
        edge_mode_t        v_mode;
        logic [SIZE_W-1:0] opacity;
        logic              nearest_mode;
    } cfg_t;

    // Item as it travels through the front next to the axis units.
    typedef struct packed {
        logic               valid;
        op_code_t           op;
        logic [ADDR_W-1:0]  addr;
        logic [TEXEL_W-1:0] data;
        logic [FRAC_W-1:0]  fx;
        logic [FRAC_W-1:0]  fy;
        logic               far;
    } front_item_t;

    // Beat carried by the queue from the front to the back.
    typedef struct packed {
        op_code_t             op;
        logic [ADDR_W-1:0]    waddr;
        logic [TEXEL_W-1:0]   wdata;
        logic [ADDR_W-1:0]    a00;
        logic [ADDR_W-1:0]    a10;
        logic [ADDR_W-1:0]    a01;
        logic [ADDR_W-1:0]    a11;
        logic [3:0]           ok;
        logic [WEIGHT_W-1:0]  w00;
        logic [WEIGHT_W-1:0]  w10;
        logic [WEIGHT_W-1:0]  w01;
        logic [WEIGHT_W-1:0]  w11;
    } q_entry_t;

    // A size of zero acts as one, a size above the limit acts as the limit.
    function automatic logic [CALC_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input int max_size);
        logic [CALC_W-1:0] res;
        if (v == '0)
            res = CALC_W'(1);
        else if (int'(v) > max_size)
            res = CALC_W'(max_size);
        else
            res = CALC_W'(v);
        return res;
    endfunction

endpackage

@@ rtl/bts_ram.sv @@
// ============================================================================
// bts_ram: generic RAM with one write port and two registered read ports
// Plain storage; a read in the same cycle as a write to that address
// returns the old contents.
// ============================================================================
module bts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read ports.
    always_ff @(posedge clk)
    begin
        rdata0_reg <= mem_reg[raddr0];
        rdata1_reg <= mem_reg[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

@@ rtl/bts_axis.sv @@
// ============================================================================
// bts_axis: edge mode mapping of one texture axis
// A pipelined restoring remainder, one quotient bit per stage, gives the
// floor modulo needed by repeat and reflect. The last stage maps the
// integer position and its right or lower neighbor and flags whether each
// lies inside the image.
// ============================================================================
module bts_axis #(
    parameter int MAX_SIZE = 256
) (
    input  logic                                 clk,
    input  logic signed [bts_pkg::COORD_W-1:0]   coord,
    input  bts_pkg::edge_mode_t                  mode,
    input  logic [$clog2(MAX_SIZE+1)-1:0]        size,
    output logic [$clog2(MAX_SIZE+1)-1:0]        pos0,
    output logic [$clog2(MAX_SIZE+1)-1:0]        pos1,
    output logic                                 in0,
    output logic                                 in1
);

    import bts_pkg::*;

    localparam int NW = $clog2(MAX_SIZE + 1);
    localparam int DW = NW + 1;
    localparam int UB = COORD_W - 1;
    localparam int SW = COORD_W + 1;

    typedef struct packed {
        logic                       neg;
        edge_mode_t                 mode;
        logic [NW-1:0]              n;
        logic [DW-1:0]              d;
        logic signed [COORD_W-1:0]  c;
        logic [UB-1:0]              u;
        logic [DW-1:0]              r;
    } stage_t;

    stage_t st_reg [0:UB];

    logic [NW-1:0] pos0_reg;
    logic [NW-1:0] pos1_reg;
    logic          in0_reg;
    logic          in1_reg;

    // Prepare the magnitude: for a negative position the remainder of its
    // complement is taken and folded back at the end.
    always_ff @(posedge clk)
    begin
        st_reg[0].neg  <= coord[COORD_W-1];
        st_reg[0].mode <= mode;
        st_reg[0].n    <= size;
        st_reg[0].d    <= (mode == EDGE_REFLECT) ? {size, 1'b0} : DW'(size);
        st_reg[0].c    <= coord;
        st_reg[0].u    <= coord[COORD_W-1] ? ~coord[UB-1:0] : coord[UB-1:0];
        st_reg[0].r    <= '0;
    end

    // One remainder step per stage.
    for (genvar k = 1; k <= UB; k++)
    begin : g_step
        logic [DW:0]   trial;
        logic [DW-1:0] r_next;

        always_comb
        begin
            trial  = {st_reg[k-1].r, st_reg[k-1].u[UB-1]};
            r_next = (trial >= {1'b0, st_reg[k-1].d}) ?
                     DW'(trial - {1'b0, st_reg[k-1].d}) : DW'(trial);
        end

        always_ff @(posedge clk)
        begin
            st_reg[k].neg  <= st_reg[k-1].neg;
            st_reg[k].mode <= st_reg[k-1].mode;
            st_reg[k].n    <= st_reg[k-1].n;
            st_reg[k].d    <= st_reg[k-1].d;
            st_reg[k].c    <= st_reg[k-1].c;
            st_reg[k].u    <= {st_reg[k-1].u[UB-2:0], 1'b0};
            st_reg[k].r    <= r_next;
        end
    end

    // Final mapping of both neighbors.
    logic [DW-1:0]        m0;
    logic [DW-1:0]        m1;
    logic [DW-1:0]        nx;
    logic signed [SW-1:0] cs0;
    logic signed [SW-1:0] cs1;
    logic signed [SW-1:0] ns;
    logic [NW-1:0]        pos0_next;
    logic [NW-1:0]        pos1_next;
    logic                 in0_next;
    logic                 in1_next;

    always_comb
    begin
        nx  = DW'(st_reg[UB].n);
        m0  = st_reg[UB].neg ? DW'(st_reg[UB].d - DW'(1) - st_reg[UB].r) : st_reg[UB].r;
        m1  = (DW'(m0 + DW'(1)) == st_reg[UB].d) ? '0 : DW'(m0 + DW'(1));
        cs0 = SW'(st_reg[UB].c);
        cs1 = cs0 + SW'(1);
        ns  = $signed({{(SW-NW){1'b0}}, st_reg[UB].n});
        pos0_next = '0;
        pos1_next = '0;
        in0_next  = 1'b1;
        in1_next  = 1'b1;
        case (st_reg[UB].mode)
            EDGE_PAD:
            begin
                pos0_next = (cs0 < 0) ? '0 : ((cs0 > ns - 1) ? NW'(st_reg[UB].n - NW'(1))
                                                             : NW'(cs0));
                pos1_next = (cs1 < 0) ? '0 : ((cs1 > ns - 1) ? NW'(st_reg[UB].n - NW'(1))
                                                             : NW'(cs1));
            end
            EDGE_REFLECT:
            begin
                pos0_next = (m0 < nx) ? NW'(m0) : NW'(st_reg[UB].d - DW'(1) - m0);
                pos1_next = (m1 < nx) ? NW'(m1) : NW'(st_reg[UB].d - DW'(1) - m1);
            end
            EDGE_REPEAT:
            begin
                pos0_next = NW'(m0);
                pos1_next = NW'(m1);
            end
            default:
            begin
                pos0_next = NW'(cs0);
                pos1_next = NW'(cs1);
                in0_next  = (cs0 >= 0) && (cs0 < ns);
                in1_next  = (cs1 >= 0) && (cs1 < ns);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pos0_reg <= pos0_next;
        pos1_reg <= pos1_next;
        in0_reg  <= in0_next;
        in1_reg  <= in1_next;
    end

    assign pos0 = pos0_reg;
    assign pos1 = pos1_reg;
    assign in0  = in0_reg;
    assign in1  = in1_reg;

endmodule

@@ rtl/bts_front.sv @@
// ============================================================================
// bts_front: accept and classify items
// Splits the sample position into integer texel and fraction, maps both
// axes through their edge modes, and forms the four store addresses and
// blend weights. Writes ride along unchanged so that order is kept.
// ============================================================================
module bts_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  bts_pkg::op_code_t                   op,
    input  logic [bts_pkg::ADDR_W-1:0]          texel_addr,
    input  logic [bts_pkg::TEXEL_W-1:0]         texel_data,
    input  logic signed [bts_pkg::SRC_W-1:0]    src_x,
    input  logic signed [bts_pkg::SRC_W-1:0]    src_y,
    input  bts_pkg::cfg_t                       cfg,
    output logic                                push,
    output bts_pkg::q_entry_t                   entry
);

    import bts_pkg::*;

    localparam int NWX = $clog2(MAX_WIDTH + 1);
    localparam int NWY = $clog2(MAX_HEIGHT + 1);
    localparam int PW  = NWX + NWY + 1;

    logic                       r0_valid_reg;
    op_code_t                   r0_op_reg;
    logic [ADDR_W-1:0]          r0_addr_reg;
    logic [TEXEL_W-1:0]         r0_data_reg;
    logic signed [HALF_W-1:0]   r0_xh_reg;
    logic signed [HALF_W-1:0]   r0_yh_reg;

    front_item_t                line_reg [0:AXIS_LAT-1];
    logic                       push_reg;
    q_entry_t                   entry_reg;

    logic [NWX-1:0]             w_size;
    logic [NWY-1:0]             h_size;
    logic signed [COORD_W-1:0]  xl;
    logic signed [COORD_W-1:0]  yl;
    logic signed [COORD_W-1:0]  w_s;
    logic signed [COORD_W-1:0]  h_s;
    logic                       far;
    front_item_t                r0_item;

    // Input stage: subtract half a texel from both coordinates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_valid_reg <= 1'b0;
        end
        else
        begin
            r0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_op_reg   <= op;
        r0_addr_reg <= texel_addr;
        r0_data_reg <= texel_data;
        r0_xh_reg   <= HALF_W'(src_x) - $signed(HALF_TEXEL);
        r0_yh_reg   <= HALF_W'(src_y) - $signed(HALF_TEXEL);
    end

    // Integer position, fraction and the far-outside test.
    always_comb
    begin
        w_size = NWX'(clamp_size(cfg.img_width, MAX_WIDTH));
        h_size = NWY'(clamp_size(cfg.img_height, MAX_HEIGHT));
        xl     = r0_xh_reg[HALF_W-1:FRAC_W];
        yl     = r0_yh_reg[HALF_W-1:FRAC_W];
        w_s    = COORD_W'(w_size);
        h_s    = COORD_W'(h_size);
        far    = (cfg.h_mode == EDGE_NONE) && (cfg.v_mode == EDGE_NONE) &&
                 ((xl < -1) || (xl > w_s) || (yl < -1) || (yl > h_s));
        r0_item.valid = r0_valid_reg;
        r0_item.op    = r0_op_reg;
        r0_item.addr  = r0_addr_reg;
        r0_item.data  = r0_data_reg;
        r0_item.fx    = r0_xh_reg[FRAC_W-1:0];
        r0_item.fy    = r0_yh_reg[FRAC_W-1:0];
        r0_item.far   = far;
    end

    // Edge mapping units, one per axis.
    logic [NWX-1:0] x0;
    logic [NWX-1:0] x1;
    logic [NWY-1:0] y0;
    logic [NWY-1:0] y1;
    logic           x0_in;
    logic           x1_in;
    logic           y0_in;
    logic           y1_in;

    bts_axis #(.MAX_SIZE(MAX_WIDTH)) u_x_axis (
        .clk   (clk),
        .coord (xl),
        .mode  (cfg.h_mode),
        .size  (w_size),
        .pos0  (x0),
        .pos1  (x1),
        .in0   (x0_in),
        .in1   (x1_in)
    );

    bts_axis #(.MAX_SIZE(MAX_HEIGHT)) u_y_axis (
        .clk   (clk),
        .coord (yl),
        .mode  (cfg.v_mode),
        .size  (h_size),
        .pos0  (y0),
        .pos1  (y1),
        .in0   (y0_in),
        .in1   (y1_in)
    );

    // Delay line that keeps the item aligned with the axis units.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AXIS_LAT; k++)
            begin
                line_reg[k] <= '0;
            end
        end
        else
        begin
            line_reg[0] <= r0_item;
            for (int k = 1; k < AXIS_LAT; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    // Store addresses and blend weights.
    front_item_t          cur;
    logic [PW-1:0]        row0;
    logic [PW-1:0]        row1;
    logic [SIZE_W-1:0]    fxi;
    logic [SIZE_W-1:0]    fyi;
    logic [SIZE_W-1:0]    fxc;
    logic [SIZE_W-1:0]    fyc;
    q_entry_t             entry_next;

    always_comb
    begin
        cur  = line_reg[AXIS_LAT-1];
        row0 = PW'(y0) * PW'(w_size);
        row1 = PW'(y1) * PW'(w_size);
        fxi  = SIZE_W'(cur.fx);
        fyi  = SIZE_W'(cur.fy);
        fxc  = FRAC_ONE - fxi;
        fyc  = FRAC_ONE - fyi;
        entry_next.op    = cur.op;
        entry_next.waddr = cur.addr;
        entry_next.wdata = cur.data;
        entry_next.a00   = ADDR_W'(row0 + PW'(x0));
        entry_next.a10   = ADDR_W'(row0 + PW'(x1));
        entry_next.a01   = ADDR_W'(row1 + PW'(x0));
        entry_next.a11   = ADDR_W'(row1 + PW'(x1));
        entry_next.ok[0] = !cur.far && x0_in && y0_in;
        entry_next.ok[1] = !cur.far && x1_in && y0_in;
        entry_next.ok[2] = !cur.far && x0_in && y1_in;
        entry_next.ok[3] = !cur.far && x1_in && y1_in;
        entry_next.w00   = WEIGHT_W'(fxc) * WEIGHT_W'(fyc);
        entry_next.w10   = WEIGHT_W'(fxi) * WEIGHT_W'(fyc);
        entry_next.w01   = WEIGHT_W'(fxc) * WEIGHT_W'(fyi);
        entry_next.w11   = WEIGHT_W'(fxi) * WEIGHT_W'(fyi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_reg <= 1'b0;
        end
        else
        begin
            push_reg <= cur.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign push  = push_reg;
    assign entry = entry_reg;

endmodule

@@ rtl/bts_queue.sv @@
// ============================================================================
// bts_queue: short queue between front and back
// Keeps the order of beats; the back takes the head whenever one is there.
// ============================================================================
module bts_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bts_pkg::q_entry_t  push_data,
    input  logic               pop,
    output logic               not_empty,
    output logic               full,
    output bts_pkg::q_entry_t  head
);

    import bts_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t          mem_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign do_push = push && (count_reg != CNT_W'(QUEUE_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : PTR_W'(wr_ptr_reg + PTR_W'(1));
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : PTR_W'(rd_ptr_reg + PTR_W'(1));
            end
            count_reg <= CNT_W'(count_reg + CNT_W'(do_push) - CNT_W'(do_pop));
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head      = mem_reg[rd_ptr_reg];

endmodule

@@ rtl/bts_back.sv @@
// ============================================================================
// bts_back: carry out writes and samples
// Two copies of the texel store give four reads a cycle. The back reads
// the 2x2 neighborhood, blends it with rounding or takes the nearest
// texel, and scales the result by opacity.
// ============================================================================
module bts_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  bts_pkg::q_entry_t              entry,
    input  bts_pkg::cfg_t                  cfg,
    output logic                           done,
    output logic [bts_pkg::CHAN_W-1:0]     red_out,
    output logic [bts_pkg::CHAN_W-1:0]     green_out,
    output logic [bts_pkg::CHAN_W-1:0]     blue_out,
    output logic [bts_pkg::CHAN_W-1:0]     alpha_out
);

    import bts_pkg::*;

    logic               we;
    logic [TEXEL_W-1:0] p00;
    logic [TEXEL_W-1:0] p10;
    logic [TEXEL_W-1:0] p01;
    logic [TEXEL_W-1:0] p11;

    assign we = take && (entry.op == OP_WRITE);

    // Both copies take every write.
    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_ram_top (
        .clk    (clk),
        .we     (we),
        .waddr  (entry.waddr),
        .wdata  (entry.wdata),
        .raddr0 (entry.a00),
        .raddr1 (entry.a10),
        .rdata0 (p00),
        .rdata1 (p10)
    );

    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_ram_bot (
        .clk    (clk),
        .we     (we),
        .waddr  (entry.waddr),
        .wdata  (entry.wdata),
        .raddr0 (entry.a01),
        .raddr1 (entry.a11),
        .rdata0 (p01),
        .rdata1 (p11)
    );

    // Side information kept next to the store read.
    logic                b1_valid_reg;
    logic [3:0]          b1_ok_reg;
    logic [WEIGHT_W-1:0] b1_w00_reg;
    logic [WEIGHT_W-1:0] b1_w10_reg;
    logic [WEIGHT_W-1:0] b1_w01_reg;
    logic [WEIGHT_W-1:0] b1_w11_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= take && (entry.op == OP_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        b1_ok_reg  <= entry.ok;
        b1_w00_reg <= entry.w00;
        b1_w10_reg <= entry.w10;
        b1_w01_reg <= entry.w01;
        b1_w11_reg <= entry.w11;
    end

    // Blend or nearest pick per channel; texels outside read as zero.
    logic [CHAN_W-1:0] acc_next [0:3];
    logic [CHAN_W-1:0] acc_reg  [0:3];
    logic              b2_valid_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            logic [CHAN_W-1:0] t00;
            logic [CHAN_W-1:0] t10;
            logic [CHAN_W-1:0] t01;
            logic [CHAN_W-1:0] t11;
            logic [SUM_W-1:0]  sum;
            t00 = b1_ok_reg[0] ? p00[CHAN_W*c +: CHAN_W] : '0;
            t10 = b1_ok_reg[1] ? p10[CHAN_W*c +: CHAN_W] : '0;
            t01 = b1_ok_reg[2] ? p01[CHAN_W*c +: CHAN_W] : '0;
            t11 = b1_ok_reg[3] ? p11[CHAN_W*c +: CHAN_W] : '0;
            sum = ROUND_HALF + SUM_W'(b1_w00_reg) * SUM_W'(t00)
                             + SUM_W'(b1_w10_reg) * SUM_W'(t10)
                             + SUM_W'(b1_w01_reg) * SUM_W'(t01)
                             + SUM_W'(b1_w11_reg) * SUM_W'(t11);
            acc_next[c] = cfg.nearest_mode ? t00 : sum[SUM_W-1 -: CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg <= 1'b0;
        end
        else
        begin
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            acc_reg[c] <= acc_next[c];
        end
    end

    // Opacity scaling with truncation; full opacity passes unchanged.
    logic [SIZE_W-1:0] alpha_k;
    logic [CHAN_W-1:0] out_next [0:3];
    logic [CHAN_W-1:0] out_reg  [0:3];
    logic              done_reg;

    always_comb
    begin
        alpha_k = (cfg.opacity > OPACITY_ONE) ? OPACITY_ONE : cfg.opacity;
        for (int c = 0; c < 4; c++)
        begin
            logic [SIZE_W+CHAN_W-1:0] prod;
            prod = alpha_k * acc_reg[c];
            out_next[c] = (alpha_k == OPACITY_ONE) ? acc_reg[c]
                                                  : prod[2*CHAN_W-1:CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            out_reg[c] <= out_next[c];
        end
    end

    assign done      = done_reg;
    assign red_out   = out_reg[0];
    assign green_out = out_reg[1];
    assign blue_out  = out_reg[2];
    assign alpha_out = out_reg[3];

endmodule

@@ rtl/bilinear_texture_sampler_core.sv @@
// A sample beat raises done after the front, queue, store read, blend and output
// stages. Throughput: one beat per cycle, writes and samples alike; the 23-step
// remainder pipeline of each axis and the two dual-read store copies keep that
// pace. Writes give no result. busy stays low in operation; the receiver cannot
// stall. Reset clears all control state and restores the register defaults; the
// texel store is not cleared and holds garbage until written.
// ============================================================================
// bilinear_texture_sampler_core: top level of the bilinear texture sampler
// Holds the configuration registers and joins front, queue and back.
// ============================================================================
module bilinear_texture_sampler_core #(
    parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 op,
    input  logic [bts_pkg::ADDR_W-1:0]           texel_addr,
    input  logic [bts_pkg::CHAN_W-1:0]           red_in,
    input  logic [bts_pkg::CHAN_W-1:0]           green_in,
    input  logic [bts_pkg::CHAN_W-1:0]           blue_in,
    input  logic [bts_pkg::CHAN_W-1:0]           alpha_in,
    input  logic signed [bts_pkg::SRC_W-1:0]     src_x_fixed,
    input  logic signed [bts_pkg::SRC_W-1:0]     src_y_fixed,
    output logic                                 done,
    output logic [bts_pkg::CHAN_W-1:0]           red_out,
    output logic [bts_pkg::CHAN_W-1:0]           green_out,
    output logic [bts_pkg::CHAN_W-1:0]           blue_out,
    output logic [bts_pkg::CHAN_W-1:0]           alpha_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import bts_pkg::*;

    cfg_t cfg_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.img_width    <= SIZE_W'(DEF_MAX_WIDTH);
            cfg_reg.img_height   <= SIZE_W'(DEF_MAX_HEIGHT);
            cfg_reg.h_mode       <= EDGE_NONE;
            cfg_reg.v_mode       <= EDGE_NONE;
            cfg_reg.opacity      <= OPACITY_ONE;
            cfg_reg.nearest_mode <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_IMG_WIDTH:  cfg_reg.img_width    <= cfg_data;
                CFG_IMG_HEIGHT: cfg_reg.img_height   <= cfg_data;
                CFG_H_MODE:     cfg_reg.h_mode       <= edge_mode_t'(cfg_data[1:0]);
                CFG_V_MODE:     cfg_reg.v_mode       <= edge_mode_t'(cfg_data[1:0]);
                CFG_OPACITY:    cfg_reg.opacity      <= cfg_data;
                CFG_NEAREST:    cfg_reg.nearest_mode <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic     accept;
    logic     push;
    q_entry_t push_data;
    logic     q_not_empty;
    logic     q_full;
    q_entry_t q_head;

    assign accept = start && !busy;
    assign busy   = q_full;

    bts_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (op_code_t'(op)),
        .texel_addr (texel_addr),
        .texel_data ({alpha_in, blue_in, green_in, red_in}),
        .src_x      (src_x_fixed),
        .src_y      (src_y_fixed),
        .cfg        (cfg_reg),
        .push       (push),
        .entry      (push_data)
    );

    bts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_not_empty),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head      (q_head)
    );

    bts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (q_not_empty),
        .entry     (q_head),
        .cfg       (cfg_reg),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out)
    );

endmodule

@@ rtl/bts_checker.sv @@
// ============================================================================
// bts_checker: port-level checks of the texture sampler
// Counts sample beats in flight and checks results against that count.
// ============================================================================
module bts_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic op,
    input logic done,
    input logic cfg_ready
);

    logic [5:0] inflight_reg;
    logic       take_sample;

    assign take_sample = start && !busy && op;

    // Samples taken whose result has not yet been shown.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= 6'(inflight_reg + 6'(take_sample) - 6'(done));
        end
    end

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("queue filled up");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port refused a write");

    a_done_owed: assert property (@(posedge clk) disable iff (!rst_n)
                                  done |-> (inflight_reg != '0))
        else $error("result without a sample in flight");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
                                inflight_reg < 6'd40)
        else $error("too many samples in flight");

endmodule

bind bilinear_texture_sampler_core bts_checker u_bts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .done      (done),
    .cfg_ready (cfg_ready)
);
